// ===== rtl/core/extent_sort_and_coalesce_top_defines.svh =====
// Assertion helpers for extent_sort_and_coalesce_top.sv, the one file that checks its own logic.
`ifndef EXTENT_SORT_AND_COALESCE_TOP_DEFINES_SVH
`define EXTENT_SORT_AND_COALESCE_TOP_DEFINES_SVH

`define ESC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/esc_pkg.sv =====
package esc_pkg;

   localparam int CNT_W = 7;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] surv;
      logic [CNT_W-1:0] ovl;
   } merge_stat_type;

endpackage

// ===== rtl/core/esc_ram.sv =====
module esc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/esc_sort_chain.sv =====
module esc_sort_chain #(
   parameter int ENTRIES = 64,
   parameter int AW      = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [AW-1:0]           load_start,
   input  logic [AW-1:0]           load_len,
   input  logic                    pop,
   output logic [AW-1:0]           head_start,
   output logic [AW-1:0]           head_len,
   output logic [esc_pkg::CNT_W-1:0] count
);

   localparam int CW = esc_pkg::CNT_W;

   logic [AW-1:0] start_ff [ENTRIES];
   logic [AW-1:0] len_ff   [ENTRIES];
   logic [AW-1:0] start_in [ENTRIES];
   logic [AW-1:0] len_in   [ENTRIES];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [ENTRIES-1:0] greater;
   logic          full;

   assign full = (count_ff == CW'(ENTRIES));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         greater[i] = (CW'(i) < count_ff) && (start_ff[i] > load_start);
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         start_in[i] = start_ff[i];
         len_in[i]   = len_ff[i];
      end
      if (pop) begin
         count_in = count_ff - CW'(1);
         for (int i = 0; i < ENTRIES - 1; i++) begin
            start_in[i] = start_ff[i+1];
            len_in[i]   = len_ff[i+1];
         end
      end else if (load && !full) begin
         count_in = count_ff + CW'(1);
         for (int i = 0; i < ENTRIES; i++) begin
            if (greater[i] || (CW'(i) == count_ff)) begin
               if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
                  start_in[i] = start_ff[(i > 0) ? i - 1 : 0];
                  len_in[i]   = len_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  start_in[i] = load_start;
                  len_in[i]   = load_len;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         start_ff[i] <= start_in[i];
         len_ff[i]   <= len_in[i];
      end
   end

   assign head_start = start_ff[0];
   assign head_len   = len_ff[0];
   assign count      = count_ff;

endmodule

// ===== rtl/core/esc_merge.sv =====
module esc_merge #(
   parameter int ENTRIES = 64,
   parameter int AW      = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [AW-1:0]                head_start,
   input  logic [AW-1:0]                head_len,
   input  logic [esc_pkg::CNT_W-1:0]    chain_count,
   output logic                         pop,
   output logic                         wr_en,
   output logic [$clog2(ENTRIES)-1:0]   wr_addr,
   output logic [2*AW-1:0]              wr_data,
   output esc_pkg::merge_stat_type      stat
);

   localparam int CW = esc_pkg::CNT_W;
   localparam logic [AW-1:0] LEN_MAX = {AW{1'b1}};

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      FLUSH
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] ref_start_ff, ref_start_in;
   logic [AW-1:0] ref_len_ff, ref_len_in;
   logic [AW:0]   ref_end_ff, ref_end_in;
   logic          have_ref_ff, have_ref_in;
   logic [CW-1:0] surv_ff, surv_in;
   logic [CW-1:0] ovl_ff, ovl_in;
   logic [AW-1:0] room;
   logic          sat;
   logic [AW:0]   head_end;
   logic [AW:0]   head_ext;

   assign room     = LEN_MAX - ref_len_ff;
   assign sat      = head_len > room;
   assign head_ext = {1'b0, head_start};
   assign head_end = head_ext + {1'b0, head_len};

   always_comb begin
      state_in     = state_ff;
      ref_start_in = ref_start_ff;
      ref_len_in   = ref_len_ff;
      ref_end_in   = ref_end_ff;
      have_ref_in  = have_ref_ff;
      surv_in      = surv_ff;
      ovl_in       = ovl_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (go) begin
               state_in    = WALK;
               have_ref_in = 1'b0;
               surv_in     = '0;
               ovl_in      = '0;
            end
         end
         WALK: begin
            if (chain_count != '0) begin
               pop = 1'b1;
               if (!have_ref_ff) begin
                  have_ref_in  = 1'b1;
                  ref_start_in = head_start;
                  ref_len_in   = head_len;
                  ref_end_in   = head_end;
               end else if (ref_end_ff != head_ext) begin
                  wr_en        = (ref_len_ff != '0);
                  surv_in      = surv_ff + CW'(wr_en);
                  ref_start_in = head_start;
                  if (ref_end_ff > head_ext) begin
                     ovl_in     = ovl_ff + CW'(1);
                     ref_len_in = '0;
                     ref_end_in = head_ext;
                  end else begin
                     ref_len_in = head_len;
                     ref_end_in = head_end;
                  end
               end else begin
                  if (sat) begin
                     ref_len_in = LEN_MAX;
                     ref_end_in = {1'b0, ref_start_ff} + {1'b0, LEN_MAX};
                  end else begin
                     ref_len_in = ref_len_ff + head_len;
                     ref_end_in = ref_end_ff + {1'b0, head_len};
                  end
               end
            end else begin
               state_in = FLUSH;
            end
         end
         FLUSH: begin
            wr_en    = have_ref_ff && (ref_len_ff != '0);
            surv_in  = surv_ff + CW'(wr_en);
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         have_ref_ff <= 1'b0;
         surv_ff     <= '0;
         ovl_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         have_ref_ff <= have_ref_in;
         surv_ff     <= surv_in;
         ovl_ff      <= ovl_in;
      end
      ref_start_ff <= ref_start_in;
      ref_len_ff   <= ref_len_in;
      ref_end_ff   <= ref_end_in;
   end

   assign wr_addr   = surv_ff[$clog2(ENTRIES)-1:0];
   assign wr_data   = {ref_start_ff, ref_len_ff};
   assign stat.done = (state_ff == FLUSH);
   assign stat.surv = surv_in;
   assign stat.ovl  = ovl_ff;

endmodule

// ===== rtl/core/esc_emit.sv =====
module esc_emit #(
   parameter int ENTRIES = 64,
   parameter int AW      = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  esc_pkg::merge_stat_type     stat,
   output logic                        rd_en,
   output logic [$clog2(ENTRIES)-1:0]  rd_addr,
   input  logic [2*AW-1:0]             rd_data,
   output logic                        strobe,
   output logic [47:0]                 out_start,
   output logic [47:0]                 out_length,
   output logic                        valid_res,
   output logic                        final_res,
   output logic [esc_pkg::CNT_W-1:0]   overlap_count
);

   localparam int CW = esc_pkg::CNT_W;

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic [CW-1:0] surv_ff, surv_in;
   logic [CW-1:0] ovl_ff, ovl_in;
   logic          strobe_ff, strobe_in;
   logic          empty_ff, empty_in;
   logic          fin_ff, fin_in;

   always_comb begin
      state_in  = state_ff;
      issue_in  = issue_ff;
      surv_in   = surv_ff;
      ovl_in    = ovl_ff;
      strobe_in = 1'b0;
      empty_in  = 1'b0;
      fin_in    = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (stat.done) begin
               surv_in  = stat.surv;
               ovl_in   = stat.ovl;
               issue_in = '0;
               if (stat.surv == '0) begin
                  strobe_in = 1'b1;
                  empty_in  = 1'b1;
                  fin_in    = 1'b1;
               end else begin
                  state_in = RUN;
               end
            end
         end
         RUN: begin
            rd_en     = 1'b1;
            strobe_in = 1'b1;
            issue_in  = issue_ff + CW'(1);
            if (issue_ff == surv_ff - CW'(1)) begin
               fin_in   = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         empty_ff  <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         empty_ff  <= empty_in;
         fin_ff    <= fin_in;
      end
      issue_ff <= issue_in;
      surv_ff  <= surv_in;
      ovl_ff   <= ovl_in;
   end

   assign rd_addr       = issue_ff[$clog2(ENTRIES)-1:0];
   assign strobe        = strobe_ff;
   assign out_start     = empty_ff ? '0 : 48'(rd_data[2*AW-1:AW]);
   assign out_length    = empty_ff ? '0 : 48'(rd_data[AW-1:0]);
   assign valid_res     = !empty_ff;
   assign final_res     = fin_ff;
   assign overlap_count = ovl_ff;

endmodule

// ===== rtl/core/extent_sort_and_coalesce_top.sv =====
// Loading: one extent accepted per cycle while busy is low; loading beats give no result.
// The beat with last set raises busy; the merge pass then walks the stored extents in
// sorted order and flushes the last run; results follow one per cycle, read back from
// the result RAM (a lone empty result when none survives); the final result drops busy.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset empties the sort chain and returns every controller to idle.
`include "extent_sort_and_coalesce_top_defines.svh"

module extent_sort_and_coalesce_top #(
   parameter int ENTRIES   = 64,
   parameter int ADDR_BITS = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [47:0]               req_start_req,
   input  logic [47:0]               req_length,
   input  logic                      req_last,
   output logic                      rsp_strobe,
   output logic [47:0]               rsp_out_start,
   output logic [47:0]               rsp_out_length,
   output logic                      rsp_valid_res,
   output logic                      rsp_final_res,
   output logic [esc_pkg::CNT_W-1:0] rsp_overlap_count
);

   localparam int AW = ADDR_BITS;
   localparam int AB = $clog2(ENTRIES);

   logic                      accept;
   logic                      busy_ff, busy_in;
   logic [AW-1:0]             load_start;
   logic [AW-1:0]             load_len;
   logic [AW-1:0]             head_start;
   logic [AW-1:0]             head_len;
   logic [esc_pkg::CNT_W-1:0] chain_count;
   logic                      pop;
   logic                      wr_en;
   logic [AB-1:0]             wr_addr;
   logic [2*AW-1:0]           wr_data;
   logic                      rd_en;
   logic [AB-1:0]             rd_addr;
   logic [2*AW-1:0]           rd_data;
   esc_pkg::merge_stat_type   stat;

   assign accept     = start && !busy_ff;
   assign load_start = AW'(req_start_req);
   assign load_len   = AW'(req_length);

   always_comb begin
      busy_in = busy_ff;
      if (accept && req_last) begin
         busy_in = 1'b1;
      end else if (rsp_strobe && rsp_final_res) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   esc_sort_chain #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_start (load_start),
      .load_len   (load_len),
      .pop        (pop),
      .head_start (head_start),
      .head_len   (head_len),
      .count      (chain_count)
   );

   esc_merge #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .go          (accept && req_last),
      .head_start  (head_start),
      .head_len    (head_len),
      .chain_count (chain_count),
      .pop         (pop),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .stat        (stat)
   );

   esc_ram #(
      .WIDTH (2 * AW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   esc_emit #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .stat          (stat),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .strobe        (rsp_strobe),
      .out_start     (rsp_out_start),
      .out_length    (rsp_out_length),
      .valid_res     (rsp_valid_res),
      .final_res     (rsp_final_res),
      .overlap_count (rsp_overlap_count)
   );

   `ESC_ASSERT_SAME(a_result_while_busy, clock, reset, rsp_strobe, busy_ff, "result beat while idle")
   `ESC_ASSERT_NEXT(a_last_sets_busy, clock, reset, accept && req_last, busy_ff, "busy not raised")
   `ESC_ASSERT_SAME(a_empty_is_final, clock, reset, rsp_strobe && !rsp_valid_res, rsp_final_res, "empty result not final")
   `ESC_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, chain_count != '0, "pop from empty chain")

endmodule

// ===== test/extent_sort_and_coalesce_top_tb.sv =====
module extent_sort_and_coalesce_top_tb;

   localparam int DEPTH = 64;
   localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [47:0] ext_start;
      logic [47:0] ext_length;
      logic        valid_res;
      logic        final_res;
      logic [6:0]  overlaps;
   } extent_result_type;

   class coalesce_scoreboard;
      logic [47:0]       sorted_start[$];
      logic [47:0]       sorted_length[$];
      extent_result_type pending[$];
      int                errors = 0;

      function void note_extent(logic [47:0] s, logic [47:0] l, logic lst);
         int pos;
         logic [47:0] len[$];
         int ref_i, surv, seen, ovl;
         logic [48:0] ext_end;
         extent_result_type r;
         if (sorted_start.size() < DEPTH) begin
            pos = sorted_start.size();
            while (pos > 0 && sorted_start[pos-1] > s) pos--;
            sorted_start.insert(pos, s);
            sorted_length.insert(pos, l);
         end
         if (!lst) return;
         len = sorted_length;
         ref_i = 0;
         ovl = 0;
         for (int i = 1; i < len.size(); i++) begin
            ext_end = {1'b0, sorted_start[ref_i]} + {1'b0, len[ref_i]};
            if (ext_end != {1'b0, sorted_start[i]}) begin
               if (ext_end > {1'b0, sorted_start[i]}) begin
                  len[i] = 0;
                  ovl++;
               end
               ref_i = i;
            end else begin
               len[ref_i] = (len[i] > AMAX - len[ref_i]) ? AMAX : len[ref_i] + len[i];
               len[i] = 0;
            end
         end
         surv = 0;
         foreach (len[i]) if (len[i] != 0) surv++;
         if (surv == 0) begin
            r = '{48'd0, 48'd0, 1'b0, 1'b1, 7'(ovl)};
            pending.insert(pending.size(), r);
         end else begin
            seen = 0;
            foreach (len[i]) begin
               if (len[i] == 0) continue;
               seen++;
               r = '{sorted_start[i], len[i], 1'b1, seen == surv, 7'(ovl)};
               pending.insert(pending.size(), r);
            end
         end
         sorted_start.delete();
         sorted_length.delete();
      endfunction

      function void check_result(extent_result_type a);
         extent_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result start %h length %h", $time, a.ext_start,
                     a.ext_length);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.ext_start !== e.ext_start) begin
            $display("%0t: out_start expected %h actual %h", $time, e.ext_start, a.ext_start);
            errors++;
         end
         if (a.ext_length !== e.ext_length) begin
            $display("%0t: out_length expected %h actual %h", $time, e.ext_length,
                     a.ext_length);
            errors++;
         end
         if (a.valid_res !== e.valid_res) begin
            $display("%0t: valid_res expected %b actual %b", $time, e.valid_res, a.valid_res);
            errors++;
         end
         if (a.final_res !== e.final_res) begin
            $display("%0t: final_res expected %b actual %b", $time, e.final_res, a.final_res);
            errors++;
         end
         if (a.overlaps !== e.overlaps) begin
            $display("%0t: overlap_count expected %0d actual %0d", $time, e.overlaps,
                     a.overlaps);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [47:0] req_start_req = 0;
   logic [47:0] req_length = 0;
   logic        req_last = 0;
   logic        rsp_strobe;
   logic [47:0] rsp_out_start;
   logic [47:0] rsp_out_length;
   logic        rsp_valid_res;
   logic        rsp_final_res;
   logic [esc_pkg::CNT_W-1:0] rsp_overlap_count;

   coalesce_scoreboard board = new();
   int idle_pct = 0;
   int cycles = 0;

   extent_sort_and_coalesce_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_strobe)
         board.check_result('{rsp_out_start, rsp_out_length, rsp_valid_res, rsp_final_res,
                              rsp_overlap_count});
   end

   task automatic send_extent(logic [47:0] s, logic [47:0] l, logic lst);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_start_req <= s;
      req_length <= l;
      req_last <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_extent(s, l, lst);
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      case ($urandom_range(3))
         0: rand48 = 48'({$urandom, $urandom});
         1: rand48 = 48'($urandom_range(40));
         2: rand48 = AMAX - 48'($urandom_range(40));
         default: rand48 = 48'($urandom_range(4)) << $urandom_range(47);
      endcase
   endfunction

   task automatic send_random_set();
      int n;
      logic [47:0] s, l;
      n = $urandom_range(1, 8);
      s = rand48();
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(4))
            0: begin s = rand48(); l = rand48(); end
            1: l = 48'($urandom_range(16));
            2: begin s = s - 48'($urandom_range(8)); l = 48'($urandom_range(16)); end
            default: l = 48'($urandom_range(1, 16));
         endcase
         send_extent(s, l, i == n - 1);
         s = s + l;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_extent(0, 0, 1);
      send_extent(AMAX, AMAX, 1);
      send_extent(100, 10, 0);
      send_extent(0, 100, 0);
      send_extent(110, 5, 0);
      send_extent(105, 3, 0);
      send_extent(100, 7, 1);
      send_extent(0, AMAX, 0);
      send_extent(AMAX, AMAX, 1);
      send_extent(10, AMAX - 5, 0);
      send_extent(10, 0, 0);
      send_extent(10, 0, 1);
      send_extent(5, 0, 0);
      send_extent(4, 3, 1);
      for (int i = 0; i < 66; i++) send_extent(48'(i * 2), 48'(1 + i % 2), i == 65);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 2) ? 36 : 67;
         for (int k = 0; k < 4; k++) send_random_set();
      end
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
